// ----- rtl/core/csv_field_tokenizer_core_assert.svh -----
// Assertion macros for the CSV field tokenizer core.
// Needs no package; the including module supplies clock, reset and signals.
`ifndef CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CFT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cft_pkg.sv -----
// Package for the CSV field tokenizer core: widths, codes and item types.
// No dependencies.
package cft_pkg;

    localparam int ROW_BITS      = 20;
    localparam int RCNT_BITS     = ROW_BITS + 1;
    localparam int COLUMN_BITS   = 12;
    localparam int CFG_DATA_BITS = ROW_BITS;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] QUOTE_RESET = 8'h22;

    localparam logic [1:0] CFG_DELIMITER = 2'd0;
    localparam logic [1:0] CFG_QUOTE     = 2'd1;
    localparam logic [1:0] CFG_FOLD      = 2'd2;
    localparam logic [1:0] CFG_SKIP_ROWS = 2'd3;

    typedef enum logic [2:0] {
        ST_START       = 3'd0,
        ST_QUOTED      = 3'd1,
        ST_MAYBE_END   = 3'd2,
        ST_AFTER_QUOTE = 3'd3,
        ST_UNQUOTED    = 3'd4
    } parse_state_t;

    typedef enum logic [2:0] {
        K_APPEND  = 3'd0,
        K_CLEAR   = 3'd1,
        K_COMMIT  = 3'd2,
        K_DISCARD = 3'd3,
        K_END     = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } cft_in_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              byte_value;
        logic [ROW_BITS-1:0]     row;
        logic [COLUMN_BITS-1:0]  column;
        logic [ROW_BITS-1:0]     row_count;
        logic                    last;
    } cft_out_t;

endpackage

// ----- rtl/core/csv_field_tokenizer_core.sv -----
// Path: an accepted input item passes the input register, then the result queue, before
// any result of it shows on m_data.
// Throughput: one input item per cycle while the result queue has room; an end item with
// a pending field gives two results at once, which the 4-entry result queue absorbs.
// s_ready drops only when the result queue holds more than two items.
// Reset: synchronous, active low; clears parse state and counters, registers to defaults.
// Top level of the CSV field tokenizer; depends on cft_pkg and the assertion header.
`include "csv_field_tokenizer_core_assert.svh"

module csv_field_tokenizer_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [cft_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  cft_pkg::cft_in_t                      s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output cft_pkg::cft_out_t                     m_data
);
    import cft_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);
    localparam int QCNT   = QPTR + 1;

    // configuration
    logic [7:0]          delim_reg;
    logic [7:0]          quote_reg;
    logic                fold_reg;
    logic [ROW_BITS-1:0] skip_reg;

    // input register
    logic    in_vld_reg;
    cft_in_t in_reg;

    // parse state
    parse_state_t           parse_state_reg, parse_state_next;
    logic [RCNT_BITS-1:0]   row_counter_reg, row_counter_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic                   prev_delim_reg, prev_delim_next;
    logic                   pending_reg, pending_next;

    // result queue
    cft_out_t         q_reg [QDEPTH];
    logic [QPTR-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT-1:0]  cnt_reg;

    logic proc_go, pop, byte_go;
    logic is_d, is_q, is_nl, is_cr;
    logic do_append, do_clear, do_finish, do_delim, do_nl;
    logic col_step, row_step;
    logic [1:0] push_n;
    cft_out_t ev_a, ev_b, emit_ev, end_ev, append_ev, clear_ev;

    logic [RCNT_BITS-1:0]   row_inc;
    logic [RCNT_BITS-1:0]   row_diff, rc_src, rc_diff;
    logic [COLUMN_BITS-1:0] column_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
            quote_reg <= QUOTE_RESET;
            fold_reg  <= 1'b0;
            skip_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELIMITER: delim_reg <= cfg_data[7:0];
                CFG_QUOTE:     quote_reg <= cfg_data[7:0];
                CFG_FOLD:      fold_reg  <= cfg_data[0];
                CFG_SKIP_ROWS: skip_reg  <= cfg_data[ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    assign proc_go = in_vld_reg && (cnt_reg <= QCNT'(QDEPTH - 2));
    assign s_ready = !in_vld_reg || proc_go;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    assign is_d    = in_reg.char_byte == delim_reg;
    assign is_q    = in_reg.char_byte == quote_reg;
    assign is_nl   = in_reg.char_byte == CHAR_LF;
    assign is_cr   = in_reg.char_byte == CHAR_CR;
    assign byte_go = proc_go && !in_reg.end_of_text && !is_cr;

    // next state
    always_comb begin
        parse_state_next = parse_state_reg;
        if (proc_go && in_reg.end_of_text) begin
            parse_state_next = ST_START;
        end else if (byte_go) begin
            case (parse_state_reg)
                ST_QUOTED: begin
                    if (is_q) begin
                        parse_state_next = ST_MAYBE_END;
                    end else if (is_nl) begin
                        parse_state_next = ST_START;
                    end
                end
                ST_MAYBE_END: begin
                    if (is_q) begin
                        parse_state_next = ST_QUOTED;
                    end else if (is_d || is_nl) begin
                        parse_state_next = ST_START;
                    end else begin
                        parse_state_next = ST_AFTER_QUOTE;
                    end
                end
                ST_AFTER_QUOTE: begin
                    if (is_d || is_nl) begin
                        parse_state_next = ST_START;
                    end
                end
                ST_UNQUOTED: begin
                    if (is_q) begin
                        parse_state_next = ST_QUOTED;
                    end else if (is_d || is_nl) begin
                        parse_state_next = ST_START;
                    end
                end
                default: begin
                    if (is_q) begin
                        parse_state_next = ST_QUOTED;
                    end else if (!is_d && !is_nl) begin
                        parse_state_next = ST_UNQUOTED;
                    end else begin
                        parse_state_next = ST_START;
                    end
                end
            endcase
        end
    end

    // actions of the current byte
    always_comb begin
        do_append = 1'b0;
        do_clear  = 1'b0;
        do_finish = 1'b0;
        do_delim  = 1'b0;
        do_nl     = 1'b0;
        case (parse_state_reg)
            ST_QUOTED: begin
                do_append = !is_q && !is_nl;
                do_finish = !is_q && is_nl;
            end
            ST_MAYBE_END: begin
                do_append = is_q;
                do_finish = !is_q && (is_d || is_nl);
            end
            ST_AFTER_QUOTE: begin
                do_finish = is_d || is_nl;
            end
            ST_UNQUOTED: begin
                do_clear  = is_q;
                do_finish = !is_q && (is_d || is_nl);
                do_append = !is_q && !is_d && !is_nl;
            end
            default: begin
                do_delim  = !is_q && is_d;
                do_nl     = !is_q && !is_d && is_nl;
                do_append = !is_q && !is_d && !is_nl;
            end
        endcase
    end

    assign col_step = do_delim || (do_finish && !is_nl);
    assign row_step = do_nl || (do_finish && is_nl);

    assign row_inc    = (&row_counter_reg) ? row_counter_reg : row_counter_reg + 1'b1;
    assign column_inc = (&column_reg) ? column_reg : column_reg + 1'b1;
    assign row_diff   = row_counter_reg - {1'b0, skip_reg};
    assign rc_src     = pending_reg ? row_inc : row_counter_reg;
    assign rc_diff    = rc_src - {1'b0, skip_reg};

    // result items
    always_comb begin
        emit_ev = '0;
        if (row_counter_reg > {1'b0, skip_reg}) begin
            emit_ev.kind   = K_COMMIT;
            emit_ev.row    = row_diff[ROW_BITS] ? '1 : row_diff[ROW_BITS-1:0];
            emit_ev.column = column_reg;
        end else begin
            emit_ev.kind = K_DISCARD;
        end

        end_ev      = '0;
        end_ev.kind = K_END;
        end_ev.last = 1'b1;
        if (rc_src > {1'b0, skip_reg}) begin
            end_ev.row_count = rc_diff[ROW_BITS] ? '1 : rc_diff[ROW_BITS-1:0];
        end

        append_ev            = '0;
        append_ev.kind       = K_APPEND;
        append_ev.byte_value = in_reg.char_byte;
        append_ev.last       = 1'b1;

        clear_ev      = '0;
        clear_ev.kind = K_CLEAR;
        clear_ev.last = 1'b1;

        ev_b   = end_ev;
        ev_a   = append_ev;
        push_n = 2'd0;
        if (proc_go && in_reg.end_of_text) begin
            if (pending_reg) begin
                ev_a   = emit_ev;
                push_n = 2'd2;
            end else begin
                ev_a   = end_ev;
                push_n = 2'd1;
            end
        end else if (byte_go) begin
            if (do_finish) begin
                ev_a      = emit_ev;
                ev_a.last = 1'b1;
                push_n    = 2'd1;
            end else if (do_clear) begin
                ev_a   = clear_ev;
                push_n = 2'd1;
            end else if (do_append) begin
                push_n = 2'd1;
            end
        end
    end

    // counters and flags
    always_comb begin
        row_counter_next = row_counter_reg;
        column_next      = column_reg;
        prev_delim_next  = prev_delim_reg;
        pending_next     = pending_reg;
        if (proc_go && in_reg.end_of_text) begin
            row_counter_next = RCNT_BITS'(1);
            column_next      = COLUMN_BITS'(1);
            prev_delim_next  = 1'b0;
            pending_next     = 1'b0;
        end else if (byte_go) begin
            if (row_step) begin
                row_counter_next = row_inc;
                column_next      = COLUMN_BITS'(1);
            end else if (col_step && (!fold_reg || !prev_delim_reg)) begin
                column_next = column_inc;
            end
            if (!is_d) begin
                prev_delim_next = 1'b0;
            end else if (col_step) begin
                prev_delim_next = 1'b1;
            end
            if (do_append) begin
                pending_next = 1'b1;
            end else if (do_clear || do_finish) begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_state_reg <= ST_START;
            row_counter_reg <= RCNT_BITS'(1);
            column_reg      <= COLUMN_BITS'(1);
            prev_delim_reg  <= 1'b0;
            pending_reg     <= 1'b0;
        end else begin
            parse_state_reg <= parse_state_next;
            row_counter_reg <= row_counter_next;
            column_reg      <= column_next;
            prev_delim_reg  <= prev_delim_next;
            pending_reg     <= pending_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= ev_a;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 1'b1] <= ev_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT'(push_n) - QCNT'(pop);
        end
    end

    assign m_valid = cnt_reg != '0;
    assign m_data  = q_reg[rd_ptr_reg];

    `CFT_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, cnt_reg <= QCNT'(QDEPTH),
        "queue overfull")
    `CFT_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !proc_go,
        cnt_reg == $past(cnt_reg) - 1'b1, "queue count wrong after pop")
    `CFT_ASSERT_NEXT(a_end_clears, aclk, aresetn, proc_go && in_reg.end_of_text,
        parse_state_reg == ST_START && row_counter_reg == RCNT_BITS'(1) && !pending_reg,
        "state not cleared after end item")
    `CFT_ASSERT_NOW(a_pending_state, aclk, aresetn, pending_reg,
        parse_state_reg != ST_START, "field pending in start state")
    `CFT_ASSERT_NOW(a_commit_column, aclk, aresetn, m_valid && m_data.kind == K_COMMIT,
        m_data.column != '0, "commit with column zero")

endmodule

// ----- sim/csv_field_tokenizer_core_test.sv -----
// Self-checking testbench for csv_field_tokenizer_core: byte stream in, field events out.
// Holds its own tokenizer model and event scoreboard; depends on cft_pkg and the RTL only.
`timescale 1ns / 1ps

module csv_field_tokenizer_core_test;
    import cft_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_HOLD    = 300;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam logic [RCNT_BITS-1:0] ROW_SAT = {1'b0, {ROW_BITS{1'b1}}};

    // tokenizer model plus the queue of events it still expects
    class field_event_board;
        logic [7:0]             delim_byte;
        logic [7:0]             quote_char;
        bit                     fold_runs;
        logic [ROW_BITS-1:0]    skip_count;
        parse_state_t           pstate;
        logic [RCNT_BITS-1:0]   row_ctr;
        logic [COLUMN_BITS-1:0] col_ctr;
        bit                     after_delim;
        bit                     field_open;
        cft_out_t               expected_events[$];
        int                     error_count;

        function new();
            delim_byte  = DELIM_RESET;
            quote_char  = QUOTE_RESET;
            fold_runs   = 1'b0;
            skip_count  = '0;
            error_count = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            pstate      = ST_START;
            row_ctr     = 1;
            col_ctr     = 1;
            after_delim = 1'b0;
            field_open  = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_DELIMITER: delim_byte = value[7:0];
                CFG_QUOTE:     quote_char = value[7:0];
                CFG_FOLD:      fold_runs  = value[0];
                CFG_SKIP_ROWS: skip_count = value[ROW_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction

        function void add_event(kind_t k, logic [7:0] b, logic [ROW_BITS-1:0] r,
                                logic [COLUMN_BITS-1:0] c, logic [ROW_BITS-1:0] rc);
            cft_out_t ev;
            ev            = '0;
            ev.kind       = k;
            ev.byte_value = b;
            ev.row        = r;
            ev.column     = c;
            ev.row_count  = rc;
            expected_events.push_back(ev);
        endfunction

        function void count_row();
            if (row_ctr != '1) row_ctr = row_ctr + 1'b1;
        endfunction

        function void count_delim();
            if (!fold_runs || !after_delim)
                if (col_ctr != '1) col_ctr = col_ctr + 1'b1;
            after_delim = 1'b1;
        endfunction

        function void close_field();
            logic [RCNT_BITS-1:0] r;
            if (row_ctr > skip_count) begin
                r = row_ctr - skip_count;
                if (r > ROW_SAT) r = ROW_SAT;
                add_event(K_COMMIT, 8'h00, r[ROW_BITS-1:0], col_ctr, '0);
            end else begin
                add_event(K_DISCARD, 8'h00, '0, '0, '0);
            end
            field_open = 1'b0;
        endfunction

        function void end_field(logic [7:0] x);
            close_field();
            if (x == CHAR_LF) begin
                count_row();
                col_ctr = 1;
            end else begin
                count_delim();
            end
            pstate = ST_START;
        endfunction

        function void append_byte(logic [7:0] x);
            add_event(K_APPEND, x, '0, '0, '0);
            field_open = 1'b1;
        endfunction

        function void note_input(cft_in_t item);
            logic [7:0]           x;
            bit                   is_d;
            bit                   is_q;
            logic [RCNT_BITS-1:0] kept;
            int                   prior;
            cft_out_t             tail;
            prior = expected_events.size();
            x     = item.char_byte;
            if (item.end_of_text) begin
                if (field_open) begin
                    close_field();
                    count_row();
                end
                kept = (row_ctr > skip_count) ? row_ctr - skip_count : '0;
                if (kept > ROW_SAT) kept = ROW_SAT;
                add_event(K_END, 8'h00, '0, '0, kept[ROW_BITS-1:0]);
                clear_parse();
            end else if (x != CHAR_CR) begin
                is_d = (x == delim_byte);
                is_q = (x == quote_char);
                case (pstate)
                    ST_QUOTED: begin
                        if (is_q) pstate = ST_MAYBE_END;
                        else if (x == CHAR_LF) end_field(x);
                        else append_byte(x);
                    end
                    ST_MAYBE_END: begin
                        if (is_q) begin
                            append_byte(x);
                            pstate = ST_QUOTED;
                        end else if (is_d || x == CHAR_LF) begin
                            end_field(x);
                        end else begin
                            pstate = ST_AFTER_QUOTE;
                        end
                    end
                    ST_AFTER_QUOTE: begin
                        if (is_d || x == CHAR_LF) end_field(x);
                    end
                    ST_UNQUOTED: begin
                        if (is_q) begin
                            add_event(K_CLEAR, 8'h00, '0, '0, '0);
                            field_open = 1'b0;
                            pstate     = ST_QUOTED;
                        end else if (is_d || x == CHAR_LF) begin
                            end_field(x);
                        end else begin
                            append_byte(x);
                        end
                    end
                    default: begin
                        if (is_q) begin
                            pstate = ST_QUOTED;
                        end else if (is_d) begin
                            count_delim();
                        end else if (x == CHAR_LF) begin
                            count_row();
                            col_ctr = 1;
                        end else begin
                            append_byte(x);
                            pstate = ST_UNQUOTED;
                        end
                    end
                endcase
                if (!is_d) after_delim = 1'b0;
            end
            if (expected_events.size() > prior) begin
                tail      = expected_events.pop_back();
                tail.last = 1'b1;
                expected_events.push_back(tail);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(cft_out_t got);
            cft_out_t want;
            if (expected_events.size() == 0) begin
                $error("result item with nothing expected: kind %0h", got.kind);
                error_count++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("row", want.row, got.row);
            compare_field("column", want.column, got.column);
            compare_field("row_count", want.row_count, got.row_count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    cft_in_t                  s_data;
    logic                     m_valid;
    logic                     m_ready;
    cft_out_t                 m_data;

    field_event_board board = new();
    longint cycle_count = 0;
    int     tx_calm = 0;
    int     rx_calm = 0;
    bit     hold_off_req = 1'b0;

    csv_field_tokenizer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // mostly short gaps, a few long ones, now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 550) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 980) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 85) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            stall = pick_gap(rx_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // called at a falling edge; leaves valid high after acceptance
    task automatic send_item(input cft_in_t item);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(item);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        cft_in_t item;
        item.char_byte   = b;
        item.end_of_text = 1'b0;
        send_item(item);
    endtask

    task automatic send_end();
        cft_in_t item;
        item.char_byte   = 8'($urandom_range(0, 255));
        item.end_of_text = 1'b1;
        send_item(item);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.outstanding() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_reg(idx, value);
        @(negedge aclk);
    endtask

    // random text built mostly from whole fields and row ends, with some noise
    task automatic send_text(input int n_items);
        int sent;
        int mode;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            mode = $urandom_range(0, 99);
            len  = $urandom_range(0, 6);
            if (mode < 30) begin
                send_byte(board.quote_char);
                sent++;
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_byte(board.quote_char);
                        send_byte(board.quote_char);
                        sent += 2;
                    end else begin
                        send_byte(pick_text_byte());
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_byte(board.quote_char);
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(pick_text_byte());
                    sent++;
                end
            end else if (mode < 85) begin
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0) send_byte(board.quote_char);
                    else send_byte(pick_text_byte());
                    sent++;
                end
            end else begin
                repeat (len) begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_byte(board.delim_byte);
                sent++;
                if ($urandom_range(0, 4) == 0) begin
                    send_byte(board.delim_byte);
                    sent++;
                end
            end else if (r < 85) begin
                send_byte(CHAR_LF);
                sent++;
            end else if (r < 92) begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                sent += 2;
            end else if (r < 96) begin
                send_end();
                sent++;
            end
        end
        send_end();
    endtask

    task automatic run_phase(input logic [7:0] d, input logic [7:0] q, input bit f,
                             input logic [ROW_BITS-1:0] s, input int n_items);
        wait_idle();
        write_reg(CFG_DELIMITER, CFG_DATA_BITS'(d));
        write_reg(CFG_QUOTE, CFG_DATA_BITS'(q));
        write_reg(CFG_FOLD, CFG_DATA_BITS'(f));
        write_reg(CFG_SKIP_ROWS, CFG_DATA_BITS'(s));
        cfg_valid <= 1'b0;
        send_text(n_items);
    endtask

    initial begin
        logic [7:0] opening[$];
        opening = '{"a", DELIM_RESET, QUOTE_RESET, "b", QUOTE_RESET, QUOTE_RESET,
                    QUOTE_RESET, DELIM_RESET, DELIM_RESET, QUOTE_RESET, "x", QUOTE_RESET,
                    "y", CHAR_CR, CHAR_LF, "z", QUOTE_RESET, "q", CHAR_LF, QUOTE_RESET,
                    CHAR_LF, 8'hFF, 8'h00};
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DELIMITER;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: quoting, doubled quote, empty and reopened fields, end with field open
        foreach (opening[i]) send_byte(opening[i]);
        send_end();
        send_end();

        run_phase(8'h3B, 8'h27, 1'b1, 20'd2, 300);
        run_phase(8'h00, 8'hFF, 1'b0, 20'hFFFFF, 200);
        run_phase(8'hFF, 8'h00, 1'b1, 20'd0, 300);
        run_phase(8'h7C, 8'h7C, 1'b0, 20'd1, 250);
        run_phase(CHAR_LF, QUOTE_RESET, 1'b1, 20'd0, 250);
        // receiver holds off while the next text goes in
        wait_idle();
        hold_off_req = 1'b1;
        run_phase(DELIM_RESET, QUOTE_RESET, 1'b0, 20'd0, 300);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 20'($urandom_range(0, 5)), 250);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.error_count == 0 && board.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
